// ===== rtl/tnt_pkg.sv =====
// shared types, constants and helpers of the text normalize tokenizer
package tnt_pkg;

    // longest minimum token length the hold buffer supports
    localparam int MAX_MIN_LEN = 8;
    localparam int LEN_W = $clog2(MAX_MIN_LEN + 2);
    localparam int IDX_W = (MAX_MIN_LEN > 1) ? $clog2(MAX_MIN_LEN) : 1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // byte constants
    localparam logic [7:0] LEAD_BYTE   = 8'hC3;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] ASCII_LIMIT = 8'd128;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] KEEP_LO1    = 8'h81;
    localparam logic [7:0] KEEP_HI1    = 8'h9C;
    localparam logic [7:0] KEEP_LO2    = 8'hA1;
    localparam logic [7:0] KEEP_HI2    = 8'hBC;

    // register indexes on the config port
    localparam logic REG_DROP_DIGITS = 1'b0;
    localparam logic REG_MIN_LEN     = 1'b1;

    // register reset values
    localparam logic       DROP_DIGITS_RST = 1'b1;
    localparam logic [3:0] MIN_LEN_RST     = 4'd2;

    // operation slots of one command, carried out lowest first
    localparam int OP_PRE  = 0;  // close token before the byte
    localparam int OP_ADD0 = 1;  // append data0
    localparam int OP_ADD1 = 2;  // append data1
    localparam int OP_POST = 3;  // close token at end of text
    localparam int OP_DONE = 4;  // done marker
    localparam int OP_N    = 5;

    typedef struct packed {
        logic [OP_N-1:0] ops;
        logic [7:0]      data0;
        logic [7:0]      data1;
    } t_cmd;

    // capital second bytes of 0xC3 pairs that fold to lower case
    function automatic logic is_capital(input logic [7:0] c);
        return (c == 8'h81) || (c == 8'h89) || (c == 8'h8D) || (c == 8'h93) ||
               (c == 8'h9A) || (c == 8'h91) || (c == 8'h9C);
    endfunction

    function automatic logic is_kept_second(input logic [7:0] c);
        return ((c >= KEEP_LO1) && (c <= KEEP_HI1)) ||
               ((c >= KEEP_LO2) && (c <= KEEP_HI2));
    endfunction

endpackage

// ===== rtl/tnt_front.sv =====
// front end: classifies each text byte into a token command
module tnt_front
    import tnt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_text_byte,
    input  logic       i_byte_valid,
    input  logic       i_end_of_text,
    input  logic       i_drop_digits,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic       r_pending;
    logic       n_pending;
    logic [7:0] lower;
    t_cmd       cmd;

    assign o_ready = !i_q_full;

    always_comb begin
        cmd       = '0;
        n_pending = r_pending;
        lower     = i_text_byte;
        if ((i_text_byte >= CHAR_UP_A) && (i_text_byte <= CHAR_UP_Z)) begin
            lower = i_text_byte + CASE_OFFSET;
        end
        if (i_byte_valid) begin
            n_pending = 1'b0;
            if (r_pending && is_capital(i_text_byte)) begin
                cmd.ops[OP_ADD0] = 1'b1;
                cmd.ops[OP_ADD1] = 1'b1;
                cmd.data0        = LEAD_BYTE;
                cmd.data1        = i_text_byte + CASE_OFFSET;
            end else if (r_pending && is_kept_second(i_text_byte)) begin
                cmd.ops[OP_ADD0] = 1'b1;
                cmd.ops[OP_ADD1] = 1'b1;
                cmd.data0        = LEAD_BYTE;
                cmd.data1        = i_text_byte;
            end else begin
                // broken pair: the lead turns into a separator
                if (r_pending) begin
                    cmd.ops[OP_PRE] = 1'b1;
                end
                if (i_text_byte == LEAD_BYTE) begin
                    n_pending = 1'b1;
                end else if (i_text_byte < ASCII_LIMIT) begin
                    if ((lower >= CHAR_LO_A) && (lower <= CHAR_LO_Z)) begin
                        cmd.ops[OP_ADD0] = 1'b1;
                        cmd.data0        = lower;
                    end else if ((i_text_byte >= CHAR_0) && (i_text_byte <= CHAR_9)) begin
                        if (!i_drop_digits) begin
                            cmd.ops[OP_ADD0] = 1'b1;
                            cmd.data0        = i_text_byte;
                        end
                    end else begin
                        cmd.ops[OP_PRE] = 1'b1;
                    end
                end else begin
                    cmd.ops[OP_PRE] = 1'b1;
                end
            end
        end
        if (i_end_of_text) begin
            // a dangling lead closes like any separator
            n_pending        = 1'b0;
            cmd.ops[OP_POST] = 1'b1;
            cmd.ops[OP_DONE] = 1'b1;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_valid && o_ready && (cmd.ops != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_pending <= n_pending;
        end
    end

endmodule

// ===== rtl/tnt_cmd_fifo.sv =====
// short command queue between front and back
module tnt_cmd_fifo
    import tnt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/tnt_back.sv =====
// back end: token assembly, hold buffer flush and output register
module tnt_back
    import tnt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    input  logic [3:0] i_min_token_len,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_token_byte,
    output logic       o_token_last,
    output logic       o_text_done
);

    logic [7:0]       r_hold [MAX_MIN_LEN];
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_lag_byte;
    logic             r_lag_valid;
    logic [IDX_W-1:0] r_idx;
    logic [OP_N-1:0]  r_done_ops;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_done;

    logic [LEN_W-1:0] n_len;
    logic [7:0]       n_lag_byte;
    logic             n_lag_valid;
    logic [IDX_W-1:0] n_idx;

    logic [LEN_W-1:0] eff_min;
    logic [LEN_W-1:0] len_inc;
    logic [OP_N-1:0]  remaining;
    logic [OP_N-1:0]  cur;
    logic             is_add;
    logic             is_end;
    logic             is_done;
    logic [7:0]       add_data;
    logic             flush;
    logic             idx_last;
    logic             want_out;
    logic             op_end;
    logic             hold_we;
    logic [7:0]       out_byte;
    logic             out_last;
    logic             out_done;
    logic             out_free;
    logic             fire;
    logic             step_done;

    // minimum length clamped to the hold buffer size, zero acts as one
    always_comb begin
        if (i_min_token_len == 4'd0) begin
            eff_min = LEN_W'(1);
        end else if (int'(i_min_token_len) > MAX_MIN_LEN) begin
            eff_min = LEN_W'(MAX_MIN_LEN);
        end else begin
            eff_min = LEN_W'(i_min_token_len);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        remaining = i_cmd.ops & ~r_done_ops;
        cur       = remaining & (~remaining + OP_N'(1));
        is_add    = cur[OP_ADD0] || cur[OP_ADD1];
        is_end    = cur[OP_PRE] || cur[OP_POST];
        is_done   = cur[OP_DONE];
        add_data  = cur[OP_ADD1] ? i_cmd.data1 : i_cmd.data0;
        flush     = !r_lag_valid && (r_len != '0) && (r_len >= eff_min);
        idx_last  = (LEN_W'(r_idx) + LEN_W'(1)) == r_len;
        len_inc   = (r_len <= LEN_W'(MAX_MIN_LEN)) ? r_len + LEN_W'(1) : r_len;

        want_out    = 1'b0;
        op_end      = 1'b1;
        hold_we     = 1'b0;
        out_byte    = '0;
        out_last    = 1'b0;
        out_done    = 1'b0;
        n_len       = r_len;
        n_lag_byte  = r_lag_byte;
        n_lag_valid = r_lag_valid;
        n_idx       = r_idx;

        if (is_done) begin
            want_out = 1'b1;
            out_done = 1'b1;
        end else if ((is_add || is_end) && flush) begin
            // stream the held bytes, one per cycle while the output is free
            want_out = 1'b1;
            out_byte = r_hold[r_idx];
            out_last = is_end && idx_last;
            if (idx_last) begin
                n_idx = '0;
                if (is_add) begin
                    n_lag_byte  = add_data;
                    n_lag_valid = 1'b1;
                    n_len       = len_inc;
                end else begin
                    n_len      = '0;
                    n_lag_byte = '0;
                end
            end else begin
                op_end = 1'b0;
                n_idx  = r_idx + IDX_W'(1);
            end
        end else if (is_add) begin
            if (r_lag_valid) begin
                want_out   = 1'b1;
                out_byte   = r_lag_byte;
                n_lag_byte = add_data;
            end else begin
                hold_we = 1'b1;
            end
            n_len = len_inc;
        end else if (is_end) begin
            if (r_lag_valid) begin
                want_out = 1'b1;
                out_byte = r_lag_byte;
                out_last = 1'b1;
            end
            n_len       = '0;
            n_lag_byte  = '0;
            n_lag_valid = 1'b0;
        end
    end

    assign fire      = i_q_valid && (cur != '0) && (!want_out || out_free);
    assign step_done = fire && op_end;
    assign o_q_pop   = step_done && ((remaining & ~cur) == '0);

    always_ff @(posedge i_clk) begin
        if (fire && hold_we) begin
            r_hold[r_len[IDX_W-1:0]] <= add_data;
        end
        if (fire && want_out) begin
            r_out_byte <= out_byte;
            r_out_last <= out_last;
            r_out_done <= out_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_lag_byte  <= '0;
            r_lag_valid <= 1'b0;
            r_idx       <= '0;
            r_done_ops  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_len       <= n_len;
                r_lag_byte  <= n_lag_byte;
                r_lag_valid <= n_lag_valid;
                r_idx       <= n_idx;
            end
            if (o_q_pop) begin
                r_done_ops <= '0;
            end else if (step_done) begin
                r_done_ops <= r_done_ops | cur;
            end
            if (fire && want_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_token_byte = r_out_byte;
    assign o_token_last = r_out_last;
    assign o_text_done  = r_out_done;

endmodule

// ===== rtl/text_normalize_tokenizer_unit.sv =====
// top level of the text normalize tokenizer with its register port
// Text bytes enter one per beat and leave as lowercased tokens, one byte per
// output beat, with token_last on the final byte of each token and a done
// beat (token_byte zero, text_done high) closing every text. The front
// classifies a byte in the cycle it is accepted and pushes a command into a
// four-entry queue; it keeps taking bytes while that queue has room, even
// while the output is stalled. The back carries out one token operation per
// cycle while its output register is free: a plain letter is a single append,
// a kept 0xC3 pair an append of each byte, and the end of a text closes the
// token, then gives the done beat. Once a token holds the minimum length
// (clamped to 1..8), the next byte or the token close streams all held bytes,
// as many as that minimum, out one per cycle while the output is free.
// Sustained rate is one byte per cycle on plain text while the output is
// ready, set by the single output register of the back end.
// Registers: 0x0 drop_digits (bit 0, reset 1), 0x4 min_token_len
// (bits 3:0, reset 2). Write them only while no text is in flight.
module text_normalize_tokenizer_unit
    import tnt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_text,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_token_byte,
    output logic        o_token_last,
    output logic        o_text_done,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_drop_digits;
    logic [3:0] r_min_token_len;
    logic       cfg_write;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd head_cmd;

    // register port: no wait states, register picked by word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_digits   <= DROP_DIGITS_RST;
            r_min_token_len <= MIN_LEN_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_DROP_DIGITS: r_drop_digits   <= pwdata[0];
                REG_MIN_LEN:     r_min_token_len <= pwdata[3:0];
                default:         r_drop_digits   <= r_drop_digits;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DROP_DIGITS: prdata = {31'd0, r_drop_digits};
            REG_MIN_LEN:     prdata = {28'd0, r_min_token_len};
            default:         prdata = '0;
        endcase
    end

    // front: classify and fold each accepted byte
    tnt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_text_byte   (i_text_byte),
        .i_byte_valid  (i_byte_valid),
        .i_end_of_text (i_end_of_text),
        .i_drop_digits (r_drop_digits),
        .i_q_full      (q_full),
        .o_ready       (o_in_ready),
        .o_push        (q_push),
        .o_cmd         (front_cmd)
    );

    // queue decouples byte intake from token output stalls
    tnt_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // back: token length tracking, hold buffer and output beat
    tnt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (head_cmd),
        .i_min_token_len (r_min_token_len),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_token_byte    (o_token_byte),
        .o_token_last    (o_token_last),
        .o_text_done     (o_text_done)
    );

endmodule

// ===== test/tb.sv =====
// self-checking testbench of the text normalize tokenizer unit
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tnt_pkg::*;

    // cycles without any beat on either channel before the run is declared hung
    localparam int HANG_LIMIT = 5000;
    // quiet cycles after the last token beat, covers queue and flush latency
    localparam int SETTLE_CYCLES = 40;
    // the block never produces more token beats than this for one text beat
    localparam int MAX_BEATS_PER_ITEM = 12;
    // at least this many random text beats per register setting
    localparam int BEATS_PER_SETTING = 13;

    // one beat on the text side
    typedef struct {
        logic [7:0] tbyte;
        logic       bvalid;
        logic       eot;
    } text_beat_t;

    // one beat on the token side
    typedef struct {
        logic [7:0] tbyte;
        logic       last;
        logic       done;
    } token_beat_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_text_byte = 8'h00;
    logic        i_byte_valid = 1'b0;
    logic        i_end_of_text = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_token_byte;
    logic        o_token_last;
    logic        o_text_done;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    text_beat_t  pending_beats[$];     // text beats waiting to be driven
    token_beat_t expected_tokens[$];   // token beats predicted, oldest first

    // register copies used by the token predictor
    logic        cfg_drop_digits = DROP_DIGITS_RST;
    logic [3:0]  cfg_min_len = MIN_LEN_RST;

    // token predictor state
    logic        lead_waiting = 1'b0;  // a 0xc3 lead waits for its second byte
    logic [7:0]  held_bytes[MAX_MIN_LEN];
    int          tok_len = 0;          // bytes in the current token, saturating
    logic [7:0]  tail_byte = 8'h00;    // newest byte of a long token, held back
    logic        tail_held = 1'b0;
    int          beats_this_item = 0;

    // bookkeeping
    int          mismatches = 0;
    int          beats_sent = 0;
    int          tokens_seen = 0;
    int          texts_closed = 0;
    int          settings_used = 1;
    int          send_gap = 0;
    int          out_pause = 0;
    int          idle_cycles = 0;
    bit          calm_stretch = 1'b0;  // no idling on either side while set

    text_normalize_tokenizer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_byte_valid  (i_byte_valid),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_token_byte  (o_token_byte),
        .o_token_last  (o_token_last),
        .o_text_done   (o_text_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------

    // record one expected token beat, at most MAX_BEATS_PER_ITEM per text beat
    function automatic void note_token(input logic [7:0] b, input logic last,
                                       input logic done);
        token_beat_t t;
        t.tbyte = b;
        t.last  = last;
        t.done  = done;
        if (beats_this_item < MAX_BEATS_PER_ITEM)
            expected_tokens.insert(expected_tokens.size(), t);
        beats_this_item++;
    endfunction

    // out-of-range minimum lengths clamp into 1..MAX_MIN_LEN
    function automatic int active_min();
        int m;
        m = int'(cfg_min_len);
        if (m < 1)
            m = 1;
        if (m > MAX_MIN_LEN)
            m = MAX_MIN_LEN;
        return m;
    endfunction

    // a short token is held until it reaches the minimum, then streamed with
    // one byte kept back so that its last flag can be set at the close
    function automatic void append_token_byte(input logic [7:0] b);
        int i;
        if (tail_held) begin
            note_token(tail_byte, 1'b0, 1'b0);
            tail_byte = b;
        end else if (tok_len < active_min()) begin
            held_bytes[tok_len] = b;
        end else begin
            for (i = 0; i < tok_len && i < MAX_MIN_LEN; i++)
                note_token(held_bytes[i], 1'b0, 1'b0);
            tail_byte = b;
            tail_held = 1'b1;
        end
        if (tok_len <= MAX_MIN_LEN)
            tok_len++;
    endfunction

    // end of a token: flush the held-back byte, or the whole short token if
    // it made the minimum, and forget it
    function automatic void close_token();
        int i;
        if (tail_held) begin
            note_token(tail_byte, 1'b1, 1'b0);
        end else if (tok_len > 0 && tok_len >= active_min()) begin
            for (i = 0; i < tok_len; i++)
                note_token(held_bytes[i], (i + 1 == tok_len), 1'b0);
        end
        tok_len   = 0;
        tail_held = 1'b0;
        tail_byte = 8'h00;
    endfunction

    // second bytes of spanish capitals, folded to their lower-case partner
    function automatic bit folds_to_lower(input logic [7:0] c);
        case (c)
            8'h81, 8'h89, 8'h8D, 8'h91, 8'h93, 8'h9A, 8'h9C: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit pair_second(input logic [7:0] c);
        return (c inside {[KEEP_LO1:KEEP_HI1], [KEEP_LO2:KEEP_HI2]});
    endfunction

    // a byte not bound to a pending lead
    function automatic void plain_byte(input logic [7:0] c);
        logic [7:0] lc;
        lc = c;
        if (c == LEAD_BYTE) begin
            lead_waiting = 1'b1;
        end else if (c < ASCII_LIMIT) begin
            if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
                lc = c + CASE_OFFSET;
            if (lc >= CHAR_LO_A && lc <= CHAR_LO_Z) begin
                append_token_byte(lc);
            end else if (lc >= CHAR_0 && lc <= CHAR_9) begin
                if (!cfg_drop_digits)
                    append_token_byte(lc);
            end else begin
                close_token();
            end
        end else begin
            close_token();
        end
    endfunction

    // expected token beats of one accepted text beat
    function automatic void predict_beat(input logic [7:0] c, input logic v,
                                         input logic e);
        beats_this_item = 0;
        if (v) begin
            if (lead_waiting) begin
                lead_waiting = 1'b0;
                if (folds_to_lower(c)) begin
                    append_token_byte(LEAD_BYTE);
                    append_token_byte(c + CASE_OFFSET);
                end else if (pair_second(c)) begin
                    append_token_byte(LEAD_BYTE);
                    append_token_byte(c);
                end else begin
                    // broken pair: the lead separates, the byte stands alone
                    close_token();
                    plain_byte(c);
                end
            end else begin
                plain_byte(c);
            end
        end
        if (e) begin
            // a lead left dangling at the end acts as a separator
            if (lead_waiting) begin
                lead_waiting = 1'b0;
                close_token();
            end
            close_token();
            note_token(8'h00, 1'b0, 1'b1);
            texts_closed++;
        end
    endfunction

    // ------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm_stretch)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // text side driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : text_driver
        logic       nxt_valid;
        text_beat_t nb;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                // predict from the payload that was on the port at this edge
                predict_beat(i_text_byte, i_byte_valid, i_end_of_text);
                beats_sent++;
                send_gap = pick_gap();
                if ($urandom_range(0, 39) == 0)
                    calm_stretch = !calm_stretch;
                nxt_valid = 1'b0;
            end
            // a beat still waiting for ready keeps its payload untouched
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_beats.size() > 0) begin
                    nb = pending_beats.pop_front();
                    i_text_byte   <= nb.tbyte;
                    i_byte_valid  <= nb.bvalid;
                    i_end_of_text <= nb.eot;
                    nxt_valid = 1'b1;
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // token side monitor and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : token_monitor
        token_beat_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                tokens_seen++;
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token beat: byte 0x%02h last %0b done %0b",
                           o_token_byte, o_token_last, o_text_done);
                    mismatches++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_token_byte !== want.tbyte) begin
                        $error("token_byte mismatch: expected 0x%02h, actual 0x%02h",
                               want.tbyte, o_token_byte);
                        mismatches++;
                    end
                    if (o_token_last !== want.last) begin
                        $error("token_last mismatch: expected %0b, actual %0b",
                               want.last, o_token_last);
                        mismatches++;
                    end
                    if (o_text_done !== want.done) begin
                        $error("text_done mismatch: expected %0b, actual %0b",
                               want.done, o_text_done);
                        mismatches++;
                    end
                end
            end
            // random back-pressure, independent of valid
            if (out_pause > 0)
                out_pause--;
            else if ($urandom_range(0, 2) == 0)
                out_pause = pick_gap();
            i_out_ready <= (out_pause == 0);
        end
    end

    // hang detection: nothing moving on either channel for too long
    always @(posedge i_clk) begin : hang_watch
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_beat(input logic [7:0] b, input logic v,
                                       input logic e);
        text_beat_t t;
        t.tbyte  = b;
        t.bvalid = v;
        t.eot    = e;
        pending_beats.insert(pending_beats.size(), t);
    endfunction

    // second byte after a lead: capitals, kept ranges, or anything at all
    function automatic logic [7:0] pick_pair_second();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 6))
                    0: return 8'h81;
                    1: return 8'h89;
                    2: return 8'h8D;
                    3: return 8'h91;
                    4: return 8'h93;
                    5: return 8'h9A;
                    default: return 8'h9C;
                endcase
            end
            1: return 8'($urandom_range(KEEP_LO1, KEEP_HI1));
            2: return 8'($urandom_range(KEEP_LO2, KEEP_HI2));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // whitespace, punctuation or a stray high byte between words
    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h20;
            3: return 8'h09;
            4: return 8'h0A;
            5: return 8'h0B;
            6: return 8'h0C;
            7: return 8'h0D;
            8: return 8'($urandom_range(8'h21, 8'h2F));
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    // one random text: mostly words with random content, some noise and
    // broken pairs, always closed by an end-of-text beat
    task automatic queue_random_text(output int n);
        int         words;
        int         len;
        int         r;
        int         w;
        int         k;
        logic [7:0] b;
        n = 0;
        words = $urandom_range(1, 5);
        for (w = 0; w < words; w++) begin
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    queue_beat(CHAR_LO_A + 8'($urandom_range(0, 25)), 1'b1, 1'b0);
                end else if (r < 68) begin
                    queue_beat(CHAR_UP_A + 8'($urandom_range(0, 25)), 1'b1, 1'b0);
                end else if (r < 80) begin
                    queue_beat(CHAR_0 + 8'($urandom_range(0, 9)), 1'b1, 1'b0);
                end else if (r < 93) begin
                    queue_beat(LEAD_BYTE, 1'b1, 1'b0);
                    queue_beat(pick_pair_second(), 1'b1, 1'b0);
                    n++;
                end else if (r < 97) begin
                    queue_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                end else begin
                    // empty beat, ignored by the block and not counted
                    queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    n--;
                end
                n++;
            end
            if (w + 1 < words) begin
                queue_beat(pick_separator(), 1'b1, 1'b0);
                n++;
            end
        end
        case ($urandom_range(0, 3))
            0: queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            1: queue_beat(CHAR_LO_A + 8'($urandom_range(0, 25)), 1'b1, 1'b1);
            2: queue_beat(LEAD_BYTE, 1'b1, 1'b1);
            default: queue_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        endcase
        n++;
    endtask

    // register write: setup cycle, then access cycle; pready is always high
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == {REG_DROP_DIGITS, 2'b00})
            cfg_drop_digits = data[0];
        else
            cfg_min_len = data[3:0];
    endtask

    // hold off until every text beat is in and every token beat is out
    task automatic wait_all_tokens();
        do
            @(negedge i_clk);
        while (pending_beats.size() != 0 || i_in_valid || expected_tokens.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_setting(input logic drop, input logic [3:0] min_len);
        int made;
        int n;
        reg_write({REG_DROP_DIGITS, 2'b00}, {31'd0, drop});
        reg_write({REG_MIN_LEN, 2'b00}, {28'd0, min_len});
        settings_used++;
        @(negedge i_clk);
        made = 0;
        while (made < BEATS_PER_SETTING) begin
            queue_random_text(n);
            made += n;
        end
        wait_all_tokens();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part under the reset settings (drop digits, minimum two)
        queue_beat(CHAR_UP_A, 1'b1, 1'b0);      // capital folds
        queue_beat(CHAR_LO_Z, 1'b1, 1'b0);
        queue_beat(CHAR_0, 1'b1, 1'b0);         // dropped digit, the token runs on across it
        queue_beat(CHAR_UP_Z, 1'b1, 1'b0);
        queue_beat(8'h20, 1'b1, 1'b0);
        queue_beat(CHAR_LO_A, 1'b1, 1'b0);
        queue_beat(CHAR_9, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b0);          // one-byte token, too short
        queue_beat(LEAD_BYTE, 1'b1, 1'b0);      // capital pair folds
        queue_beat(8'h81, 1'b1, 1'b0);
        queue_beat(LEAD_BYTE, 1'b1, 1'b0);      // top of the second kept range
        queue_beat(8'hBC, 1'b1, 1'b0);
        queue_beat(8'h62, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b0);          // high byte separates
        queue_beat(LEAD_BYTE, 1'b1, 1'b0);      // lead then plain ascii
        queue_beat(CHAR_UP_A, 1'b1, 1'b0);
        queue_beat(LEAD_BYTE, 1'b1, 1'b0);      // lead then a fresh lead
        queue_beat(LEAD_BYTE, 1'b1, 1'b0);
        queue_beat(8'hA1, 1'b1, 1'b0);
        queue_beat(8'h7F, 1'b0, 1'b0);          // empty beat does nothing
        queue_beat(8'h9C, 1'b1, 1'b0);          // second byte with no lead
        queue_beat(8'h71, 1'b1, 1'b0);
        queue_beat(LEAD_BYTE, 1'b1, 1'b1);      // lead at end of text
        queue_beat(8'h00, 1'b0, 1'b1);          // empty text
        queue_beat(8'h6D, 1'b1, 1'b1);          // short text, only the marker
        wait_all_tokens();

        // random texts over several register settings, extremes included;
        // each setting starts only once the block has drained
        run_random_setting(1'b0, 4'd1);
        run_random_setting(1'b1, 4'd8);
        run_random_setting(1'b0, 4'd15);        // saturates to the maximum
        run_random_setting(1'b1, 4'd0);         // acts as one
        run_random_setting(1'b0, 4'd3);
        run_random_setting(1'b1, 4'd5);

        $display("covered %0d text beats in %0d texts, %0d token beats checked",
                 beats_sent, texts_closed, tokens_seen);
        $display("over %0d register settings: digits kept and dropped, minimum 0 to 15",
                 settings_used);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tnt_pkg.sv
rtl/tnt_front.sv
rtl/tnt_cmd_fifo.sv
rtl/tnt_back.sv
rtl/text_normalize_tokenizer_unit.sv
test/tb.sv
